/* sv/brl_pkg.sv */
package brl_pkg;

	localparam int NumChunks = 64;
	localparam int AddrW     = (NumChunks > 1) ? $clog2(NumChunks) : 1;
	localparam int SlotW     = 6;
	localparam int SizeW     = 32;
	localparam int TotalW    = 38;
	localparam int BudgetW   = 40;
	localparam int CountW    = 32;
	localparam int MaxEvict  = 63;

	localparam logic CmdFill   = 1'b0;
	localparam logic CmdForget = 1'b1;

	typedef struct packed {
		logic             valid;
		logic [SlotW-1:0] id;
		logic [SizeW-1:0] size;
	} cell_t;

	typedef struct packed {
		logic             append;
		logic             remove;
		logic [SlotW-1:0] id;
		logic [SizeW-1:0] size;
	} chain_op_t;

endpackage

/* sv/brl_if.sv */
interface brl_in_if;
	logic                      valid;
	logic                      ready;
	logic                      command;
	logic [brl_pkg::SlotW-1:0] chunk;
	logic [brl_pkg::SizeW-1:0] fill_size;
	logic [brl_pkg::SlotW-1:0] protect_lo;
	logic [brl_pkg::SlotW-1:0] protect_hi;
	logic                      group_end;

	modport source (output valid, command, chunk, fill_size, protect_lo, protect_hi,
		group_end, input ready);
	modport sink (input valid, command, chunk, fill_size, protect_lo, protect_hi,
		group_end, output ready);
endinterface

interface brl_out_if;
	logic                       valid;
	logic                       ready;
	logic [brl_pkg::SlotW-1:0]  evicted_chunk;
	logic                       is_eviction;
	logic [brl_pkg::TotalW-1:0] resident_total;
	logic [brl_pkg::CountW-1:0] fill_count;
	logic                       is_last;

	modport source (output valid, evicted_chunk, is_eviction, resident_total, fill_count,
		is_last, input ready);
	modport sink (input valid, evicted_chunk, is_eviction, resident_total, fill_count,
		is_last, output ready);
endinterface

/* sv/brl_ram.sv */
module brl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* sv/brl_cell.sv */
module brl_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  brl_pkg::chain_op_t op,
	input  brl_pkg::cell_t     nbr,
	input  logic               prev_valid,
	input  logic               kill_in,
	output brl_pkg::cell_t     st,
	output logic               kill_out
);
	import brl_pkg::*;

	cell_t st_q;
	logic  match;

	assign st       = st_q;
	assign match    = st_q.valid && (st_q.id == op.id);
	assign kill_out = op.remove && (kill_in || match);

	// shift down from the neighbour once the removed entry lies at or below us
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (kill_out) begin
			st_q <= nbr;
		end else if (op.append && !st_q.valid && prev_valid) begin
			st_q <= '{valid: 1'b1, id: op.id, size: op.size};
		end
	end
endmodule

/* sv/byte_budget_lru_residency_top.sv */
// Byte-budget LRU residency tracker.
// Channel cmd carries fill and forget beats; channel res returns result beats.
// cfg_we/cfg_wdata write the byte budget (zero = unlimited); write it only
// while the block is idle.
// The recency queue is a row of cells, one per chunk slot, oldest at cell 0.
// A fill appends at the first free cell; a forget or an eviction removes
// an entry and every cell above it takes its neighbour's contents in the
// same cycle. Fill counters live in a small RAM with a valid bit per slot.
// Sequence: accept in S_IDLE (the counter RAM is read then), counter and
// chain update in S_FILL, the status beat in S_STATUS. A group end with a
// nonzero budget passes through S_EVICT, one victim per cycle while the
// receiver takes beats, until the walk stops; the chain update sets this pace.
// The next beat is taken once the status beat sits in the output register,
// even while the receiver still holds it off.
// Reset empties the queue, clears the byte total, the budget and all fill
// counters (through their valid bits); no clearing pass is needed.
// A stalled receiver freezes eviction and status steps; nothing is lost.
module byte_budget_lru_residency_top (
	input  logic                         clk,
	input  logic                         arst_n,
	brl_in_if.sink                       cmd,
	brl_out_if.source                    res,
	input  logic                         cfg_we,
	input  logic [brl_pkg::BudgetW-1:0]  cfg_wdata
);
	import brl_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_FILL   = 4'b0010,
		S_EVICT  = 4'b0100,
		S_STATUS = 4'b1000
	} state_t;

	state_t state_q;

	// latched item
	logic              command_q;
	logic [SlotW-1:0]  chunk_q;
	logic [SizeW-1:0]  fill_size_q;
	logic [SlotW-1:0]  protect_lo_q;
	logic [SlotW-1:0]  protect_hi_q;
	logic              group_end_q;
	logic              bad_q;

	logic [BudgetW-1:0] budget_q;
	logic [TotalW-1:0]  total_q;
	logic [CountW-1:0]  cnt_q;
	logic [SlotW-1:0]   n_q;
	logic [NumChunks-1:0] fvalid_q;

	// output register
	logic               out_valid_q;
	logic [SlotW-1:0]   out_ev_q;
	logic               out_is_ev_q;
	logic [TotalW-1:0]  out_total_q;
	logic [CountW-1:0]  out_cnt_q;
	logic               out_last_q;

	logic accept, out_free, out_load;
	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign out_free  = !out_valid_q || res.ready;

	assign res.valid          = out_valid_q;
	assign res.evicted_chunk  = out_ev_q;
	assign res.is_eviction    = out_is_ev_q;
	assign res.resident_total = out_total_q;
	assign res.fill_count     = out_cnt_q;
	assign res.is_last        = out_last_q;

	// fill counter store
	logic [CountW-1:0] ram_rdata, cnt_cur, cnt_new;
	logic              ram_we;

	brl_ram #(.WIDTH(CountW), .DEPTH(NumChunks)) u_cnt_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (chunk_q[AddrW-1:0]),
		.wdata (cnt_new),
		.re    (accept),
		.raddr (cmd.chunk[AddrW-1:0]),
		.rdata (ram_rdata)
	);

	assign cnt_cur = fvalid_q[chunk_q[AddrW-1:0]] ? ram_rdata : '0;
	assign cnt_new = (cnt_cur == {CountW{1'b1}}) ? cnt_cur : cnt_cur + CountW'(1);
	assign ram_we  = (state_q == S_FILL) && !bad_q && (command_q == CmdFill);

	// chain of cells
	chain_op_t op;
	cell_t     st    [NumChunks];
	logic      kill  [NumChunks];

	for (genvar i = 0; i < NumChunks; i++) begin : g_cell
		cell_t nbr_w;
		logic  pv_w, kin_w;
		if (i == NumChunks - 1) begin : g_last
			assign nbr_w = '0;
		end else begin : g_mid
			assign nbr_w = st[i+1];
		end
		if (i == 0) begin : g_head
			assign pv_w  = 1'b1;
			assign kin_w = 1'b0;
		end else begin : g_body
			assign pv_w  = st[i-1].valid;
			assign kin_w = kill[i-1];
		end
		brl_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.nbr        (nbr_w),
			.prev_valid (pv_w),
			.kill_in    (kin_w),
			.st         (st[i]),
			.kill_out   (kill[i])
		);
	end

	// look up the latched chunk in the chain
	logic             hit;
	logic [SizeW-1:0] hit_size;
	always_comb begin
		hit      = 1'b0;
		hit_size = '0;
		for (int i = 0; i < NumChunks; i++) begin
			if (st[i].valid && (st[i].id == chunk_q)) begin
				hit      = 1'b1;
				hit_size = hit_size | st[i].size;
			end
		end
	end

	// byte total arithmetic
	logic [TotalW:0]    sum_w;
	logic [TotalW-1:0]  total_add, total_fgt, total_ev;
	logic [TotalW-1:0]  head_sz, hit_sz;
	assign head_sz   = TotalW'(st[0].size);
	assign hit_sz    = TotalW'(hit_size);
	assign sum_w     = {1'b0, total_q} + {1'b0, TotalW'(fill_size_q)};
	assign total_add = sum_w[TotalW] ? {TotalW{1'b1}} : sum_w[TotalW-1:0];
	assign total_fgt = (total_q > hit_sz) ? total_q - hit_sz : '0;
	assign total_ev  = (total_q > head_sz) ? total_q - head_sz : '0;

	// eviction test on the oldest entry
	logic prot, do_evict;
	assign prot     = (st[0].id >= protect_lo_q) && (st[0].id <= protect_hi_q);
	assign do_evict = (n_q != SlotW'(MaxEvict)) && st[0].valid && !prot &&
		({{(BudgetW-TotalW){1'b0}}, total_q} > budget_q);

	// load the output register with a victim or the status beat
	assign out_load = out_free &&
		(((state_q == S_EVICT) && do_evict) || (state_q == S_STATUS));

	always_comb begin
		op = '0;
		if (state_q == S_FILL && !bad_q) begin
			if (command_q == CmdFill && !hit) begin
				op.append = 1'b1;
				op.id     = chunk_q;
				op.size   = fill_size_q;
			end else if (command_q == CmdForget && hit) begin
				op.remove = 1'b1;
				op.id     = chunk_q;
			end
		end else if (state_q == S_EVICT && do_evict && out_free) begin
			op.remove = 1'b1;
			op.id     = st[0].id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= '0;
		end else if (cfg_we) begin
			budget_q <= cfg_wdata;
		end
	end

	// hold the item for the whole sequence
	always_ff @(posedge clk) begin
		if (accept) begin
			command_q    <= cmd.command;
			chunk_q      <= cmd.chunk;
			fill_size_q  <= cmd.fill_size;
			protect_lo_q <= cmd.protect_lo;
			protect_hi_q <= cmd.protect_hi;
			group_end_q  <= cmd.group_end;
			bad_q        <= ({1'b0, cmd.chunk} >= (SlotW+1)'(NumChunks));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			cnt_q       <= '0;
			n_q         <= '0;
			fvalid_q    <= '0;
			out_valid_q <= 1'b0;
			out_ev_q    <= '0;
			out_is_ev_q <= 1'b0;
			out_total_q <= '0;
			out_cnt_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					n_q <= '0;
					if (bad_q) begin
						cnt_q   <= '0;
						state_q <= S_STATUS;
					end else if (command_q == CmdFill) begin
						cnt_q <= cnt_new;
						fvalid_q[chunk_q[AddrW-1:0]] <= 1'b1;
						if (!hit) begin
							total_q <= total_add;
						end
						state_q <= (group_end_q && budget_q != '0) ? S_EVICT : S_STATUS;
					end else begin
						cnt_q <= cnt_cur;
						if (hit) begin
							total_q <= total_fgt;
						end
						state_q <= S_STATUS;
					end
				end
				S_EVICT: begin
					if (!do_evict) begin
						state_q <= S_STATUS;
					end else if (out_free) begin
						total_q     <= total_ev;
						n_q         <= n_q + SlotW'(1);
						out_ev_q    <= st[0].id;
						out_is_ev_q <= 1'b1;
						out_total_q <= total_ev;
						out_cnt_q   <= '0;
						out_last_q  <= 1'b0;
					end
				end
				S_STATUS: begin
					if (out_free) begin
						out_ev_q    <= '0;
						out_is_ev_q <= 1'b0;
						out_total_q <= total_q;
						out_cnt_q   <= cnt_q;
						out_last_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
